/* hdl/pip_pkg.sv */
// Package for the point-in-polygon block: coordinate and vertex types,
// command, plane and register codes, and the projection helpers.
// No dependencies; every module of the block imports it.
package pip_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int COORD_W      = 16;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int NV_W         = $clog2(MAX_VERTICES + 1);

  typedef logic signed [COORD_W-1:0]   coord_t;
  typedef logic signed [COORD_W:0]     diff_t;
  typedef logic signed [2*COORD_W+1:0] prod_t;
  typedef logic signed [2*COORD_W+2:0] sum_t;

  // x sits in the lowest bits, matching the packing of the input item.
  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } vertex_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  // One edge together with its neighbors, already projected to (u, v).
  typedef struct packed {
    coord_t pu;
    coord_t pv;
    coord_t y0;
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
    coord_t y3;
  } edge_win_t;

  typedef struct packed {
    logic clear;
    logic valid;
  } edge_ctl_t;

  typedef struct packed {
    logic parity;
    logic bound;
  } edge_acc_t;

  typedef enum logic [1:0] {
    ER_NONE  = 2'd0,
    ER_CROSS = 2'd1,
    ER_BOUND = 2'd2
  } edge_res_t;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] PLANE_XY = 2'd0;
  localparam logic [1:0] PLANE_XZ = 2'd1;
  localparam logic [1:0] PLANE_YZ = 2'd2;

  localparam logic REG_VCOUNT = 1'b0;
  localparam logic REG_PLANE  = 1'b1;

  function automatic coord_t proj_u(vertex_t vx, logic [1:0] plane);
    coord_t r;
    case (plane)
      PLANE_XY, PLANE_XZ: r = vx.x;
      default:            r = vx.y;
    endcase
    return r;
  endfunction

  function automatic coord_t proj_v(vertex_t vx, logic [1:0] plane);
    coord_t r;
    case (plane)
      PLANE_XY: r = vx.y;
      default:  r = vx.z;
    endcase
    return r;
  endfunction

endpackage

/* hdl/pip_vertex_cell.sv */
// One cell of the vertex ring: holds a single polygon vertex.
// Loaded from the input item or shifted from its neighbor; uses pip_pkg.
module pip_vertex_cell
  import pip_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  vertex_t   load_data,
  input  vertex_t   next_data,
  output vertex_t   vertex
);

  vertex_t vertex_r;
  vertex_t vertex_nxt;

  always_comb begin
    vertex_nxt = vertex_r;
    if (ctl.load) begin
      vertex_nxt = load_data;
    end else if (ctl.shift) begin
      vertex_nxt = next_data;
    end
  end

  always_ff @(posedge clk) begin
    vertex_r <= vertex_nxt;
  end

  assign vertex = vertex_r;

endmodule

/* hdl/pip_edge_unit.sv */
// Three-stage edge tester: compares and differences, cross products,
// then sign of the sum and accumulation of parity and boundary; uses pip_pkg.
module pip_edge_unit
  import pip_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  edge_ctl_t ctl,
  input  edge_win_t win,
  output edge_acc_t acc
);

  // Stage A registers.
  logic      va_r;
  logic      need_mul_a_r;
  logic      up_a_r;
  logic      endv_a_r;
  logic      endx_a_r;
  edge_res_t code_a_r;
  diff_t     dx1_r, dd_r, dx21_r, num_r;

  // Stage B registers.
  logic      vb_r;
  logic      need_mul_b_r;
  logic      up_b_r;
  logic      endv_b_r;
  logic      endx_b_r;
  edge_res_t code_b_r;
  prod_t     p1_r, p2_r;

  edge_acc_t acc_r, acc_nxt;

  logic      early0, horiz, up, hit, in_span, flank;
  edge_res_t hcode, code_a_nxt;
  sum_t      tsum;
  logic      st_pos;
  edge_res_t code_c;

  always_comb begin
    early0  = (win.pu > win.x1) && (win.pu > win.x2);
    horiz   = (win.y1 == win.y2);
    up      = (win.y2 > win.y1);
    in_span = ((win.x1 <= win.pu) && (win.pu <= win.x2)) ||
              ((win.x2 <= win.pu) && (win.pu <= win.x1));
    // Neighbors of a horizontal edge on the same side of the ray line.
    flank   = ((win.y1 > win.y0) && (win.y2 > win.y3)) ||
              ((win.y1 < win.y0) && (win.y2 < win.y3));
    hcode   = ER_NONE;
    if (win.pv == win.y1) begin
      if (in_span) begin
        hcode = ER_BOUND;
      end else if (flank) begin
        hcode = ER_CROSS;
      end
    end
    hit = up ? ((win.pv > win.y1) && (win.pv <= win.y2))
             : ((win.pv < win.y1) && (win.pv >= win.y2));
    if (early0) begin
      code_a_nxt = ER_NONE;
    end else if (horiz) begin
      code_a_nxt = hcode;
    end else begin
      code_a_nxt = ER_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= ctl.valid;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    need_mul_a_r <= !early0 && !horiz && hit;
    up_a_r       <= up;
    endv_a_r     <= (win.pv == win.y2);
    endx_a_r     <= up ? (win.y2 <= win.y3) : (win.y2 >= win.y3);
    code_a_r     <= code_a_nxt;
    dx1_r        <= diff_t'(win.x1) - diff_t'(win.pu);
    dd_r         <= diff_t'(win.y2) - diff_t'(win.y1);
    dx21_r       <= diff_t'(win.x2) - diff_t'(win.x1);
    num_r        <= diff_t'(win.pv) - diff_t'(win.y1);

    need_mul_b_r <= need_mul_a_r;
    up_b_r       <= up_a_r;
    endv_b_r     <= endv_a_r;
    endx_b_r     <= endx_a_r;
    code_b_r     <= code_a_r;
    p1_r         <= dx1_r * dd_r;
    p2_r         <= dx21_r * num_r;
  end

  always_comb begin
    tsum   = sum_t'(p1_r) + sum_t'(p2_r);
    // The ray parameter is positive when the sum has the sign of the edge's rise.
    st_pos = (tsum != '0) && (tsum[$bits(sum_t)-1] != up_b_r);
    code_c = code_b_r;
    if (need_mul_b_r) begin
      if (tsum == '0) begin
        code_c = ER_BOUND;
      end else if (st_pos) begin
        code_c = (!endv_b_r || endx_b_r) ? ER_CROSS : ER_NONE;
      end else begin
        code_c = ER_NONE;
      end
    end
    acc_nxt = acc_r;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (vb_r) begin
      acc_nxt.bound  = acc_r.bound | (code_c == ER_BOUND);
      acc_nxt.parity = acc_r.parity ^ (code_c == ER_CROSS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

/* hdl/point_in_polygon_test.sv */
// Top level of the point-in-polygon block: channels, registers, control,
// the ring of vertex cells and the edge tester; uses pip_pkg.
//
//   channel | direction | handshake             | contents
//   in_     | slave     | in_tvalid/in_tready   | tuser: cmd; tdata: index, x, y, z
//   out_    | master    | out_tvalid/out_tready | tdata: inside_res, on_boundary
//   cfg_    | APB slave | psel/penable/pready   | vertex_count at 0, projection_plane at 4
//
// A load item leaves the block idle. A query blocks the input from acceptance
// until its result enters the output register, n being the clamped vertex count:
// the ring of n cells rotates once, one edge per cycle, into a three-stage
// edge tester. The result waits in an output register; a following query
// stalls in its done state while that register is still full.
// Reset is synchronous and restores the registers to 3 vertices, plane x,y.
module point_in_polygon_test
  import pip_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // [3:0] vertex_index, [19:4] coord_x,
                                  // [35:20] coord_y, [51:36] coord_z, zero pad
  input  logic [0:0]  in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] inside_res, [1] on_boundary, zero pad
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic              drain_r, drain_nxt;
  logic [4:0]        vcount_r;
  logic [1:0]        plane_r;
  coord_t            pu_r, pv_r;
  logic              out_valid_r;
  logic              out_inside_r, out_bound_r;

  logic              in_fire, is_query, cfg_wr, out_free;
  logic [NV_W-1:0]   n_eff;
  logic [IDX_W-1:0]  last_idx;
  vertex_t           in_vertex;
  logic [3:0]        in_index;
  vertex_t           cells [MAX_VERTICES];
  edge_win_t         win;
  edge_ctl_t         ectl;
  edge_acc_t         acc;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign is_query   = (in_tuser[0] == CMD_QUERY);
  assign in_index   = in_tdata[3:0];
  assign in_vertex  = in_tdata[51:4];
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign out_free   = !out_valid_r || out_tready;

  // Register file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= 5'd3;
      plane_r  <= PLANE_XY;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_VCOUNT: vcount_r <= cfg_pwdata[4:0];
        REG_PLANE:  plane_r  <= cfg_pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_VCOUNT: cfg_prdata = {27'd0, vcount_r};
      REG_PLANE:  cfg_prdata = {30'd0, plane_r};
      default:    cfg_prdata = '0;
    endcase
  end

  always_comb begin
    if (32'(vcount_r) > MAX_VERTICES) begin
      n_eff = NV_W'(MAX_VERTICES);
    end else if (vcount_r < 5'd3) begin
      n_eff = NV_W'(3);
    end else begin
      n_eff = NV_W'(vcount_r);
    end
    last_idx = IDX_W'(n_eff - 1'b1);
  end

  // Vertex ring: cell k takes from cell k+1, the last used cell from cell 0.
  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    cell_ctl_t cctl;
    vertex_t   nbr;
    always_comb begin
      cctl.load  = in_fire && !is_query && (32'(in_index) == k);
      cctl.shift = (state_r == S_RUN) && (32'(last_idx) >= k);
      if (k == MAX_VERTICES - 1) begin
        nbr = cells[0];
      end else if (32'(last_idx) == k) begin
        nbr = cells[0];
      end else begin
        nbr = cells[(k + 1) % MAX_VERTICES];
      end
    end
    pip_vertex_cell u_cell (
      .clk       (clk),
      .ctl       (cctl),
      .load_data (in_vertex),
      .next_data (nbr),
      .vertex    (cells[k])
    );
  end

  // With the ring turned by r, cells 0..3 hold vertices r..r+3, so the
  // edge starting at vertex r+1 is tested. A triangle wraps to cell 0.
  always_comb begin
    win.pu = pu_r;
    win.pv = pv_r;
    win.y0 = proj_v(cells[0], plane_r);
    win.x1 = proj_u(cells[1], plane_r);
    win.y1 = proj_v(cells[1], plane_r);
    win.x2 = proj_u(cells[2], plane_r);
    win.y2 = proj_v(cells[2], plane_r);
    win.y3 = (n_eff == NV_W'(3)) ? proj_v(cells[0], plane_r)
                                 : proj_v(cells[3], plane_r);
    ectl.valid = (state_r == S_RUN);
    ectl.clear = in_fire && is_query;
  end

  pip_edge_unit u_edge (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ectl),
    .win   (win),
    .acc   (acc)
  );

  always_ff @(posedge clk) begin
    if (in_fire && is_query) begin
      pu_r <= proj_u(in_vertex, plane_r);
      pv_r <= proj_v(in_vertex, plane_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    drain_nxt = drain_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && is_query) begin
          state_nxt = S_RUN;
          cnt_nxt   = '0;
        end
      end
      S_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == last_idx) begin
          state_nxt = S_DRAIN;
          drain_nxt = 1'b0;
        end
      end
      S_DRAIN: begin
        drain_nxt = 1'b1;
        if (drain_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      drain_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drain_r <= drain_nxt;
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && out_free) begin
      out_inside_r <= acc.parity | acc.bound;
      out_bound_r  <= acc.bound;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_bound_r, out_inside_r};

  a_bound_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_bound_r || out_inside_r))
    else $error("boundary result without inside flag");

  a_query_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_query) |=> ((state_r == S_RUN) && (cnt_r == '0)))
    else $error("query did not start the ring rotation");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (cnt_r <= last_idx))
    else $error("edge counter ran past the vertex count");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the done state");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_fire)
    else $error("item accepted while a query is in progress");

endmodule
